FILE: rtl/swa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_pkg
// Types and constants shared by the swept box collision pipeline.
// ----------------------------------------------------------------------------
package swa_pkg;

   localparam int CW    = 27;   // working width for edges and distances
   localparam int DW    = 20;   // motion magnitude / divisor width
   localparam int RW    = 21;   // divider remainder width
   localparam int PW    = 48;   // cross product width
   localparam int QBITS = 17;   // quotient bits, 0.16 plus the 1.0 bit

   localparam logic [QBITS-1:0] ONE_Q16 = 17'h10000;

   localparam logic [1:0] OUTCOME_NONE    = 2'd0;
   localparam logic [1:0] OUTCOME_OVERLAP = 2'd1;
   localparam logic [1:0] OUTCOME_HIT     = 2'd2;
   localparam logic [1:0] OUTCOME_MISS    = 2'd3;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_OVERLAP,
      KIND_MISS,
      KIND_DIVIDE
   } swa_kind_type;

   // per-axis entry/exit ratios, numerators already sign-normalized
   typedef struct packed {
      logic                 hit;
      logic                 ovl;
      logic signed [CW-1:0] xn;
      logic signed [CW-1:0] xx;
      logic signed [CW-1:0] yn;
      logic signed [CW-1:0] yx;
      logic [DW-1:0]        dx;
      logic [DW-1:0]        dy;
      logic                 xz;
      logic                 yz;
      logic                 xneg;
      logic                 yneg;
   } swa_ratio_type;

   // word traveling down the divider
   typedef struct packed {
      swa_kind_type     kind;
      logic             selx;
      logic             xneg;
      logic             yneg;
      logic [RW-1:0]    rem;
      logic [DW-1:0]    den;
      logic [QBITS-1:0] quo;
   } swa_div_type;

endpackage

FILE: rtl/swa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_front
// Geometry stages: relative motion, edges, swept and static overlap tests,
// entry/exit distances and their normalization to positive denominators.
// ----------------------------------------------------------------------------
module swa_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [23:0]           moving_x,
   input  logic signed [23:0]           moving_y,
   input  logic [19:0]                  moving_w,
   input  logic [19:0]                  moving_h,
   input  logic signed [18:0]           moving_dx,
   input  logic signed [18:0]           moving_dy,
   input  logic signed [23:0]           target_x,
   input  logic signed [23:0]           target_y,
   input  logic [19:0]                  target_w,
   input  logic [19:0]                  target_h,
   input  logic signed [18:0]           target_dx,
   input  logic signed [18:0]           target_dy,
   output logic                         out_valid,
   output swa_pkg::swa_ratio_type       out_ratio
);

   localparam int CW = swa_pkg::CW;
   localparam int DW = swa_pkg::DW;

   // stage 1
   logic                 v1_ff;
   logic signed [CW-1:0] vx1_ff, vy1_ff, mx1_ff, my1_ff, mr1_ff, mb1_ff;
   logic signed [CW-1:0] sx1_ff, sy1_ff, sr1_ff, sb1_ff;
   // stage 2
   logic                 v2_ff, hit2_ff, ovl2_ff, hit2_in, ovl2_in;
   logic signed [CW-1:0] vx2_ff, vy2_ff, exn2_ff, exx2_ff, eyn2_ff, eyx2_ff;
   logic signed [CW-1:0] exn2_in, exx2_in, eyn2_in, eyx2_in;
   // stage 3
   logic                   v3_ff;
   swa_pkg::swa_ratio_type r3_ff, r3_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      vx1_ff <= CW'(moving_dx) - CW'(target_dx);
      vy1_ff <= CW'(moving_dy) - CW'(target_dy);
      mx1_ff <= CW'(moving_x);
      my1_ff <= CW'(moving_y);
      mr1_ff <= CW'(moving_x) + $signed({7'b0, moving_w});
      mb1_ff <= CW'(moving_y) + $signed({7'b0, moving_h});
      sx1_ff <= CW'(target_x);
      sy1_ff <= CW'(target_y);
      sr1_ff <= CW'(target_x) + $signed({7'b0, target_w});
      sb1_ff <= CW'(target_y) + $signed({7'b0, target_h});
   end

   always_comb begin
      logic                 xpos, ypos;
      logic signed [CW-1:0] bl, br, bt, bb;
      xpos = vx1_ff > 0;
      ypos = vy1_ff > 0;
      // swept box: stretch the moving box along the motion
      bl = xpos ? mx1_ff : mx1_ff + vx1_ff;
      br = xpos ? mr1_ff + vx1_ff : mr1_ff;
      bt = ypos ? my1_ff : my1_ff + vy1_ff;
      bb = ypos ? mb1_ff + vy1_ff : mb1_ff;
      hit2_in = (bb > sy1_ff) && (bt < sb1_ff) && (bl < sr1_ff) && (br > sx1_ff);
      ovl2_in = (mb1_ff > sy1_ff) && (my1_ff < sb1_ff) &&
                (mx1_ff < sr1_ff) && (mr1_ff > sx1_ff);
      exn2_in = xpos ? sx1_ff - mr1_ff : sr1_ff - mx1_ff;
      exx2_in = xpos ? sr1_ff - mx1_ff : sx1_ff - mr1_ff;
      eyn2_in = ypos ? sy1_ff - mb1_ff : sb1_ff - my1_ff;
      eyx2_in = ypos ? sb1_ff - my1_ff : sy1_ff - mb1_ff;
   end

   always_ff @(posedge clock) begin
      hit2_ff <= hit2_in;
      ovl2_ff <= ovl2_in;
      vx2_ff  <= vx1_ff;
      vy2_ff  <= vy1_ff;
      exn2_ff <= exn2_in;
      exx2_ff <= exx2_in;
      eyn2_ff <= eyn2_in;
      eyx2_ff <= eyx2_in;
   end

   always_comb begin
      logic signed [CW-1:0] ax, ay;
      r3_in.hit  = hit2_ff;
      r3_in.ovl  = ovl2_ff;
      r3_in.xneg = vx2_ff < 0;
      r3_in.yneg = vy2_ff < 0;
      r3_in.xz   = vx2_ff == 0;
      r3_in.yz   = vy2_ff == 0;
      // flip numerators so each denominator is positive
      r3_in.xn   = r3_in.xneg ? -exn2_ff : exn2_ff;
      r3_in.xx   = r3_in.xneg ? -exx2_ff : exx2_ff;
      r3_in.yn   = r3_in.yneg ? -eyn2_ff : eyn2_ff;
      r3_in.yx   = r3_in.yneg ? -eyx2_ff : eyx2_ff;
      ax         = r3_in.xneg ? -vx2_ff : vx2_ff;
      ay         = r3_in.yneg ? -vy2_ff : vy2_ff;
      r3_in.dx   = ax[DW-1:0];
      r3_in.dy   = ay[DW-1:0];
   end

   always_ff @(posedge clock) begin
      r3_ff <= r3_in;
   end

   assign out_valid = v3_ff;
   assign out_ratio = r3_ff;

endmodule

FILE: rtl/swa_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_cmp
// Ratio compare stages: cross products, then the exact time compares that
// pick the entry time, the normal axis and the miss cases.
// ----------------------------------------------------------------------------
module swa_cmp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  swa_pkg::swa_ratio_type  in_ratio,
   output logic                    out_valid,
   output swa_pkg::swa_div_type    out_div
);

   localparam int CW = swa_pkg::CW;
   localparam int DW = swa_pkg::DW;
   localparam int PW = swa_pkg::PW;
   localparam int RW = swa_pkg::RW;

   logic                   v4_ff, v5_ff;
   swa_pkg::swa_ratio_type r4_ff;
   logic signed [PW-1:0]   p_xn_dy_ff, p_yn_dx_ff, p_yx_dx_ff, p_xx_dy_ff;
   swa_pkg::swa_div_type   d5_ff, d5_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [CW-1:0] xn, xx, yn, yx;
      logic signed [DW:0]   sdx, sdy;
      xn = in_ratio.xn;
      xx = in_ratio.xx;
      yn = in_ratio.yn;
      yx = in_ratio.yx;
      sdx = $signed({1'b0, in_ratio.dx});
      sdy = $signed({1'b0, in_ratio.dy});
      r4_ff      <= in_ratio;
      p_xn_dy_ff <= PW'(xn) * PW'(sdy);
      p_yn_dx_ff <= PW'(yn) * PW'(sdx);
      p_yx_dx_ff <= PW'(yx) * PW'(sdx);
      p_xx_dy_ff <= PW'(xx) * PW'(sdy);
   end

   always_comb begin
      logic signed [CW-1:0] xn, xx, yn, yx, sdx, sdy, num;
      logic                 xz, yz, gt_xy, miss;
      xn  = r4_ff.xn;
      xx  = r4_ff.xx;
      yn  = r4_ff.yn;
      yx  = r4_ff.yx;
      sdx = $signed({7'b0, r4_ff.dx});
      sdy = $signed({7'b0, r4_ff.dy});
      xz  = r4_ff.xz;
      yz  = r4_ff.yz;
      // no motion on an axis: entry at minus infinity, exit at plus infinity
      gt_xy = xz ? 1'b0 : (yz ? 1'b1 : (p_xn_dy_ff > p_yn_dx_ff));
      miss  = (!xz && (xn > xx)) || (!yz && (yn > yx)) ||
              (!xz && !yz && (p_xn_dy_ff > p_yx_dx_ff)) ||
              (!xz && !yz && (p_yn_dx_ff > p_xx_dy_ff)) ||
              ((xz || xn < 0) && (yz || yn < 0)) ||
              (!xz && (xn > sdx)) || (!yz && (yn > sdy)) ||
              (xz && yz);
      num = gt_xy ? xn : yn;

      if (!r4_ff.hit) begin
         d5_in.kind = swa_pkg::KIND_NONE;
      end else if (r4_ff.ovl) begin
         d5_in.kind = swa_pkg::KIND_OVERLAP;
      end else if (miss) begin
         d5_in.kind = swa_pkg::KIND_MISS;
      end else begin
         d5_in.kind = swa_pkg::KIND_DIVIDE;
      end
      d5_in.selx = gt_xy;
      d5_in.xneg = r4_ff.xneg;
      d5_in.yneg = r4_ff.yneg;
      d5_in.rem  = num[RW-1:0];
      d5_in.den  = gt_xy ? r4_ff.dx : r4_ff.dy;
      d5_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      d5_ff <= d5_in;
   end

   assign out_valid = v5_ff;
   assign out_div   = d5_ff;

endmodule

FILE: rtl/swa_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_div_stage
// One register stage of the restoring divider: STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module swa_div_stage #(
   parameter int   STEPS      = 4,
   parameter logic FIRST_STEP = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  swa_pkg::swa_div_type  in_div,
   output logic                  out_valid,
   output swa_pkg::swa_div_type  out_div
);

   localparam int RW    = swa_pkg::RW;
   localparam int QBITS = swa_pkg::QBITS;

   logic                 v_ff;
   swa_pkg::swa_div_type d_ff, d_in;

   always_comb begin
      logic [RW-1:0] t;
      d_in = in_div;
      for (int k = 0; k < STEPS; k++) begin
         // the 1.0 bit compares the numerator unshifted
         if (FIRST_STEP && k == 0) begin
            t = d_in.rem;
         end else begin
            t = {d_in.rem[RW-2:0], 1'b0};
         end
         if (t >= {1'b0, d_in.den}) begin
            t = t - {1'b0, d_in.den};
            d_in.quo = {d_in.quo[QBITS-2:0], 1'b1};
         end else begin
            d_in.quo = {d_in.quo[QBITS-2:0], 1'b0};
         end
         d_in.rem = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_div   = d_ff;

endmodule

FILE: rtl/swept_aabb_collision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_aabb_collision
// Swept box pair collision test: broadphase, overlap, entry time and normal.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy is never raised. Each word passes
// through an 11 stage pipeline (3 geometry, 2 ratio compare, 5 divider,
// 1 output) from an accepted start to the rsp_valid strobe.
// Reset clears every stage valid bit; no result is in flight after reset.
// The receiver cannot stall, so results leave on the strobe unconditionally.
// ----------------------------------------------------------------------------
module swept_aabb_collision (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_moving_x,
   input  logic signed [23:0] req_moving_y,
   input  logic [19:0]        req_moving_w,
   input  logic [19:0]        req_moving_h,
   input  logic signed [18:0] req_moving_dx,
   input  logic signed [18:0] req_moving_dy,
   input  logic signed [23:0] req_target_x,
   input  logic signed [23:0] req_target_y,
   input  logic [19:0]        req_target_w,
   input  logic [19:0]        req_target_h,
   input  logic signed [18:0] req_target_dx,
   input  logic signed [18:0] req_target_dy,
   output logic               rsp_valid,
   output logic [1:0]         rsp_outcome,
   output logic [16:0]        rsp_entry_time,
   output logic signed [1:0]  rsp_normal_x,
   output logic signed [1:0]  rsp_normal_y,
   output logic [16:0]        rsp_remaining_time
);

   localparam int QBITS = swa_pkg::QBITS;

   logic                   accept;
   logic                   ratio_valid;
   swa_pkg::swa_ratio_type ratio;
   logic                   dv0, dv1, dv2, dv3, dv4, dv5;
   swa_pkg::swa_div_type   dd0, dd1, dd2, dd3, dd4, dd5;

   logic                   valid_ff;
   logic [1:0]             outcome_ff, outcome_in;
   logic [QBITS-1:0]       entry_ff, entry_in, remain_ff, remain_in;
   logic signed [1:0]      nx_ff, nx_in, ny_ff, ny_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   swa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .moving_x  (req_moving_x),
      .moving_y  (req_moving_y),
      .moving_w  (req_moving_w),
      .moving_h  (req_moving_h),
      .moving_dx (req_moving_dx),
      .moving_dy (req_moving_dy),
      .target_x  (req_target_x),
      .target_y  (req_target_y),
      .target_w  (req_target_w),
      .target_h  (req_target_h),
      .target_dx (req_target_dx),
      .target_dy (req_target_dy),
      .out_valid (ratio_valid),
      .out_ratio (ratio)
   );

   swa_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ratio_valid),
      .in_ratio  (ratio),
      .out_valid (dv0),
      .out_div   (dd0)
   );

   swa_div_stage #(.STEPS(4), .FIRST_STEP(1'b1)) u_div1 (
      .clock(clock), .reset(reset), .in_valid(dv0), .in_div(dd0),
      .out_valid(dv1), .out_div(dd1)
   );
   swa_div_stage #(.STEPS(4), .FIRST_STEP(1'b0)) u_div2 (
      .clock(clock), .reset(reset), .in_valid(dv1), .in_div(dd1),
      .out_valid(dv2), .out_div(dd2)
   );
   swa_div_stage #(.STEPS(4), .FIRST_STEP(1'b0)) u_div3 (
      .clock(clock), .reset(reset), .in_valid(dv2), .in_div(dd2),
      .out_valid(dv3), .out_div(dd3)
   );
   swa_div_stage #(.STEPS(4), .FIRST_STEP(1'b0)) u_div4 (
      .clock(clock), .reset(reset), .in_valid(dv3), .in_div(dd3),
      .out_valid(dv4), .out_div(dd4)
   );
   swa_div_stage #(.STEPS(1), .FIRST_STEP(1'b0)) u_div5 (
      .clock(clock), .reset(reset), .in_valid(dv4), .in_div(dd4),
      .out_valid(dv5), .out_div(dd5)
   );

   always_comb begin
      outcome_in = swa_pkg::OUTCOME_NONE;
      entry_in   = swa_pkg::ONE_Q16;
      remain_in  = '0;
      nx_in      = 2'sd0;
      ny_in      = 2'sd0;
      unique case (dd5.kind)
         swa_pkg::KIND_NONE: begin
            outcome_in = swa_pkg::OUTCOME_NONE;
         end
         swa_pkg::KIND_OVERLAP: begin
            outcome_in = swa_pkg::OUTCOME_OVERLAP;
         end
         swa_pkg::KIND_MISS: begin
            outcome_in = swa_pkg::OUTCOME_MISS;
         end
         swa_pkg::KIND_DIVIDE: begin
            entry_in  = dd5.quo;
            remain_in = swa_pkg::ONE_Q16 - dd5.quo;
            if (dd5.quo < swa_pkg::ONE_Q16) begin
               outcome_in = swa_pkg::OUTCOME_HIT;
               // push back against the relative motion on the later axis
               if (dd5.selx) begin
                  nx_in = dd5.xneg ? 2'sd1 : -2'sd1;
               end else begin
                  ny_in = dd5.yneg ? 2'sd1 : -2'sd1;
               end
            end else begin
               outcome_in = swa_pkg::OUTCOME_MISS;
            end
         end
         default: begin
            outcome_in = swa_pkg::OUTCOME_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dv5;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      entry_ff   <= entry_in;
      remain_ff  <= remain_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_entry_time     = entry_ff;
   assign rsp_normal_x       = nx_ff;
   assign rsp_normal_y       = ny_ff;
   assign rsp_remaining_time = remain_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 11))
      else $error("result without a start word 11 cycles earlier");

   a_hit_times: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == swa_pkg::OUTCOME_HIT) |->
      (rsp_entry_time < swa_pkg::ONE_Q16 &&
       rsp_remaining_time == swa_pkg::ONE_Q16 - rsp_entry_time))
      else $error("hit with inconsistent entry and remaining time");

   a_normal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != swa_pkg::OUTCOME_HIT) |->
      (rsp_normal_x == 2'sd0 && rsp_normal_y == 2'sd0 &&
       rsp_entry_time == swa_pkg::ONE_Q16))
      else $error("normal or entry time set without a hit");

   a_normal_one_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == swa_pkg::OUTCOME_HIT) |->
      ((rsp_normal_x == 2'sd0) != (rsp_normal_y == 2'sd0)))
      else $error("hit normal not on exactly one axis");

endmodule
